### src/pdq_pkg.sv
// Shared types and constants for the priority deque with key search.
package pdq_pkg;

  localparam int KeyW          = 32;
  localparam int ValW          = 8;
  localparam int PosW          = 7;
  localparam int QueueDepthDef = 64;
  localparam int CmdQDepth     = 2;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_URGENT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    op_e             op;
    logic            writes;   // add or urgent insert
    logic            at_head;  // urgent insert places the word at the head
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } cmd_t;

endpackage

### src/pdq_front.sv
// Input stage: takes request words and decodes them into commands.
module pdq_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_operation,
  input  logic [pdq_pkg::KeyW-1:0] in_entry_key,
  input  logic [pdq_pkg::ValW-1:0] in_entry_value,
  output logic                     push_valid,
  output pdq_pkg::cmd_t            push_cmd,
  input  logic                     push_stall
);
  import pdq_pkg::*;

  op_e op;

  assign op = op_e'(in_operation);

  always_comb begin
    push_cmd.op      = op;
    push_cmd.writes  = (op == OP_ADD) || (op == OP_URGENT);
    push_cmd.at_head = (op == OP_URGENT);
    push_cmd.key     = in_entry_key;
    push_cmd.value   = in_entry_value;
  end

  assign push_valid = in_valid;
  assign in_stall   = push_stall;

  // a word is only taken while the command queue has room
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && push_stall) |-> in_stall)
    else $error("front accepted a word into a full command queue");

endmodule

### src/pdq_cmd_fifo.sv
// Short command queue between the decode front and the execution engine.
module pdq_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  input  pdq_pkg::cmd_t push_cmd,
  output logic          push_stall,
  output logic          pop_valid,
  output pdq_pkg::cmd_t pop_cmd,
  input  logic          pop_ready
);
  import pdq_pkg::*;

  localparam int AW = (CmdQDepth > 1) ? $clog2(CmdQDepth) : 1;
  localparam int LW = $clog2(CmdQDepth + 1);

  cmd_t          q_r [CmdQDepth];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0] level_r, level_nxt;
  logic          push, pop;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(CmdQDepth - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign push_stall = (level_r == LW'(CmdQDepth));
  assign pop_valid  = (level_r != '0);
  assign pop_cmd    = q_r[rd_ptr_r];
  assign push       = push_valid && !push_stall;
  assign pop        = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    level_nxt  = level_r;
    if (push && !pop) begin
      level_nxt = level_r + LW'(1);
    end else if (pop && !push) begin
      level_nxt = level_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LW'(CmdQDepth))
    else $error("command queue level overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (level_r == $past(level_r) + LW'(1)))
    else $error("command queue level did not grow on push");

endmodule

### src/pdq_engine.sv
// Execution engine: ring storage, head and count, search sequencer and result register.
module pdq_engine #(
  parameter int QUEUE_DEPTH = pdq_pkg::QueueDepthDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  input  pdq_pkg::cmd_t            cmd,
  output logic                     cmd_pop,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [pdq_pkg::KeyW-1:0] out_result_key,
  output logic [pdq_pkg::ValW-1:0] out_result_value,
  output logic [pdq_pkg::PosW-1:0] out_result_position
);
  import pdq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_REMOVE,
    S_SCAN
  } state_t;

  logic [KeyW-1:0] key_mem [QUEUE_DEPTH];
  logic [ValW-1:0] val_mem [QUEUE_DEPTH];
  logic [KeyW-1:0] rd_key_r;
  logic [ValW-1:0] rd_val_r;

  state_t          state_r, state_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   scan_slot_r, scan_slot_nxt;
  logic [PW-1:0]   scan_idx_r, scan_idx_nxt;
  logic [KeyW-1:0] scan_key_r, scan_key_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_e         out_status_r, out_status_nxt;
  logic [KeyW-1:0] out_key_r, out_key_nxt;
  logic [ValW-1:0] out_val_r, out_val_nxt;
  logic [PosW-1:0] out_pos_r, out_pos_nxt;

  logic            full, empty, out_free, last_entry;
  logic            wr_en;
  logic [PW-1:0]   wr_addr, rd_addr, head_inc, head_dec, tail;
  logic [PW:0]     tail_sum;
  logic [PosW-1:0] pos_full;

  function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] s);
    if (s == PW'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return s + PW'(1);
  endfunction

  assign full       = (count_r == CW'(QUEUE_DEPTH));
  assign empty      = (count_r == '0);
  assign out_free   = !out_valid_r || !out_stall;
  assign head_inc   = slot_inc(head_r);
  assign head_dec   = (head_r == '0) ? PW'(QUEUE_DEPTH - 1) : head_r - PW'(1);
  // count is below depth whenever the tail is used
  assign tail_sum   = {1'b0, head_r} + {1'b0, count_r[PW-1:0]};
  assign tail       = (tail_sum >= (PW + 1)'(QUEUE_DEPTH))
                      ? PW'(tail_sum - (PW + 1)'(QUEUE_DEPTH)) : tail_sum[PW-1:0];
  assign last_entry = (({1'b0, scan_idx_r} + (PW + 1)'(1)) == (PW + 1)'(count_r));
  // position wraps at its field width
  assign pos_full   = PosW'(scan_idx_r) + PosW'(1);
  assign rd_addr    = (state_r == S_IDLE) ? head_r : scan_slot_r;
  assign wr_addr    = cmd.at_head ? head_dec : tail;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    scan_slot_nxt  = scan_slot_r;
    scan_idx_nxt   = scan_idx_r;
    scan_key_nxt   = scan_key_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_val_nxt    = out_val_r;
    out_pos_nxt    = out_pos_r;
    cmd_pop        = 1'b0;
    wr_en          = 1'b0;

    case (state_r)
      S_IDLE: begin
        // the result register is free at pop time and only this engine fills it
        if (cmd_valid && out_free) begin
          cmd_pop        = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_key_nxt    = '0;
          out_val_nxt    = '0;
          out_pos_nxt    = '0;
          if (cmd.writes) begin
            if (full) begin
              out_status_nxt = STAT_FULL;
            end else begin
              wr_en     = 1'b1;
              count_nxt = count_r + CW'(1);
              if (cmd.at_head) begin
                head_nxt = head_dec;
              end
            end
          end else if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            out_valid_nxt = 1'b0;
            case (cmd.op)
              OP_REMOVE: begin
                head_nxt  = head_inc;
                count_nxt = count_r - CW'(1);
                state_nxt = S_REMOVE;
              end
              OP_SEARCH: begin
                scan_slot_nxt = head_inc;
                scan_idx_nxt  = '0;
                scan_key_nxt  = cmd.key;
                state_nxt     = S_SCAN;
              end
              default: begin
                out_valid_nxt = 1'b1;
              end
            endcase
          end
        end
      end
      S_REMOVE: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = STAT_OK;
        out_key_nxt    = rd_key_r;
        out_val_nxt    = rd_val_r;
        out_pos_nxt    = '0;
        state_nxt      = S_IDLE;
      end
      S_SCAN: begin
        // read data arrives in the cycle after its address, one entry compared per cycle
        if (rd_key_r == scan_key_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_OK;
          out_key_nxt    = rd_key_r;
          out_val_nxt    = rd_val_r;
          out_pos_nxt    = pos_full;
          state_nxt      = S_IDLE;
        end else if (last_entry) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOT_FOUND;
          out_key_nxt    = '0;
          out_val_nxt    = '0;
          out_pos_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          scan_idx_nxt  = scan_idx_r + PW'(1);
          scan_slot_nxt = slot_inc(scan_slot_r);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      scan_slot_r  <= '0;
      scan_idx_r   <= '0;
      scan_key_r   <= '0;
      out_status_r <= STAT_OK;
      out_key_r    <= '0;
      out_val_r    <= '0;
      out_pos_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      scan_slot_r  <= scan_slot_nxt;
      scan_idx_r   <= scan_idx_nxt;
      scan_key_r   <= scan_key_nxt;
      out_status_r <= out_status_nxt;
      out_key_r    <= out_key_nxt;
      out_val_r    <= out_val_nxt;
      out_pos_r    <= out_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= cmd.key;
      val_mem[wr_addr] <= cmd.value;
    end
    rd_key_r <= key_mem[rd_addr];
    rd_val_r <= val_mem[rd_addr];
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_key      = out_key_r;
  assign out_result_value    = out_val_r;
  assign out_result_position = out_pos_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> ($stable(head_r) && $stable(count_r)))
    else $error("head or count moved outside command pop");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (({1'b0, scan_idx_r}) < (PW + 1)'(count_r)))
    else $error("search ran past the last entry");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && !cmd.writes && empty) |=> (state_r == S_IDLE && out_valid_r))
    else $error("empty remove or search did not answer at once");

endmodule

### src/priority_deque_with_key_search.sv
// Top level of the priority deque with key search: front, command queue and engine.
// Request words are decoded by the front and held in a two-entry command queue, so
// new words are taken while the queue has room, also while the engine is busy or a
// result waits at the output. The engine answers add, urgent insert and any full or
// empty case directly from its idle state and a remove through its remove state. A
// search reads one stored entry per cycle through the single read port of the ring
// storage and ends at the first key match counted from the head.
module priority_deque_with_key_search #(
  parameter int QUEUE_DEPTH = pdq_pkg::QueueDepthDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_operation,
  input  logic [pdq_pkg::KeyW-1:0] in_entry_key,
  input  logic [pdq_pkg::ValW-1:0] in_entry_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_status,
  output logic [pdq_pkg::KeyW-1:0] out_result_key,
  output logic [pdq_pkg::ValW-1:0] out_result_value,
  output logic [pdq_pkg::PosW-1:0] out_result_position
);
  import pdq_pkg::*;

  logic push_valid, push_stall;
  cmd_t push_cmd;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  pdq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_entry_key   (in_entry_key),
    .in_entry_value (in_entry_value),
    .push_valid     (push_valid),
    .push_cmd       (push_cmd),
    .push_stall     (push_stall)
  );

  pdq_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_stall (push_stall),
    .pop_valid  (cmd_valid),
    .pop_cmd    (cmd),
    .pop_ready  (cmd_pop)
  );

  pdq_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (cmd_valid),
    .cmd                 (cmd),
    .cmd_pop             (cmd_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_result_key      (out_result_key),
    .out_result_value    (out_result_value),
    .out_result_position (out_result_position)
  );

endmodule
